>>> design/mbdpl_pkg.sv
// Shared types and constants for the multi-button debouncer with press latches.
`default_nettype none

package mbdpl_pkg;

    // Item kind carried on the input tuser.
    typedef enum logic
    {
        KIND_SAMPLE = 1'b0,
        KIND_FETCH  = 1'b1
    } kind_t;

    localparam int RAW_WIDTH      = 5;
    localparam int TIME_WIDTH     = 32;
    localparam int INTERVAL_WIDTH = 16;
    localparam int ACTION_WIDTH   = 3;
    localparam int DOWN_INDEX     = 3;

    localparam logic [INTERVAL_WIDTH-1:0] INTERVAL_RESET = 16'd50;

    // Register byte addresses on the configuration port.
    localparam int            ADDR_WIDTH             = 3;
    localparam logic [2:0]    ADDR_DEBOUNCE_INTERVAL = 3'd0;
    localparam int            APB_DATA_WIDTH         = 32;

    localparam int IN_TDATA_WIDTH  = 40;
    localparam int OUT_TDATA_WIDTH = 8;

    typedef struct packed
    {
        logic [TIME_WIDTH-1:0] now_ms;
        logic [RAW_WIDTH-1:0]  raw_levels;
        kind_t                 kind;
    } item_t;

endpackage

`default_nettype wire

>>> design/multi_button_debounce_press_latch.sv
// Top level: stream handshakes, APB register, input and result registers.
//
//  channel   dir   handshake                 payload
//  s_*       in    s_tvalid / s_tready       tdata: raw_levels, now_ms; tuser: kind
//  m_*       out   m_tvalid / m_tready       tdata: action_code, down_held
//  apb       in    psel, penable, pready     paddr, pwdata, prdata (debounce_interval)
//
// One item per cycle while the result side is not stalled; an accepted item
// passes through the input register, then per-button compare/subtract into
// the result register. All buttons are handled in parallel in the same cycle.
// Reset clears the handshake state, latches and change times, sets the stable
// levels high, and debounce_interval comes up at 50. A stalled result holds
// while the input register can still take one new item if it is empty.
`default_nettype none

module multi_button_debounce_press_latch #(
    parameter int BUTTON_COUNT = 5
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // s_tdata: [4:0] raw_levels, [36:5] now_ms, [39:37] zero
    input  wire logic [mbdpl_pkg::IN_TDATA_WIDTH-1:0]   s_tdata,
    // s_tuser: [0] kind
    input  wire logic                                   s_tuser,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // m_tdata: [2:0] action_code, [3] down_held, [7:4] zero
    output logic      [mbdpl_pkg::OUT_TDATA_WIDTH-1:0]  m_tdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [mbdpl_pkg::ADDR_WIDTH-1:0]       paddr,
    input  wire logic [mbdpl_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic      [mbdpl_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                        pready
);

    logic                                       stage_valid_reg;
    mbdpl_pkg::item_t                           stage_item_reg;
    logic                                       out_valid_reg;
    logic [mbdpl_pkg::ACTION_WIDTH-1:0]         out_action_reg;
    logic                                       out_down_reg;
    logic [mbdpl_pkg::INTERVAL_WIDTH-1:0]       interval_reg;
    logic                                       advance;
    logic                                       in_xfer;
    logic                                       cfg_write;
    logic [mbdpl_pkg::ACTION_WIDTH-1:0]         action_code;
    logic                                       down_held;
    mbdpl_pkg::item_t                           in_item;

    assign in_item.kind       = mbdpl_pkg::kind_t'(s_tuser);
    assign in_item.raw_levels = s_tdata[mbdpl_pkg::RAW_WIDTH-1:0];
    assign in_item.now_ms     =
        s_tdata[mbdpl_pkg::RAW_WIDTH +: mbdpl_pkg::TIME_WIDTH];

    assign advance  = stage_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !stage_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {
        (mbdpl_pkg::OUT_TDATA_WIDTH - mbdpl_pkg::ACTION_WIDTH - 1)'(0),
        out_down_reg, out_action_reg};

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr == mbdpl_pkg::ADDR_DEBOUNCE_INTERVAL);
    assign prdata    = (paddr == mbdpl_pkg::ADDR_DEBOUNCE_INTERVAL)
                       ? mbdpl_pkg::APB_DATA_WIDTH'(interval_reg) : '0;

    mbdpl_button_bank #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_bank (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .item        (stage_item_reg),
        .interval    (interval_reg),
        .action_code (action_code),
        .down_held   (down_held)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            interval_reg    <= mbdpl_pkg::INTERVAL_RESET;
        end
        else
        begin
            if (in_xfer)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stage_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_write)
            begin
                interval_reg <= pwdata[mbdpl_pkg::INTERVAL_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            stage_item_reg <= in_item;
        end
        if (advance)
        begin
            out_action_reg <= action_code;
            out_down_reg   <= down_held;
        end
    end

    // An item waiting in the input register is never dropped.
    a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !advance |=> stage_valid_reg)
        else $error("input register lost an item");

    // Every processed item shows up as a result next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed item produced no result");

    // A register write lands in the interval register.
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> interval_reg == $past(pwdata[mbdpl_pkg::INTERVAL_WIDTH-1:0]))
        else $error("debounce interval write lost");

endmodule

`default_nettype wire

>>> design/mbdpl_button_bank.sv
// Per-button debounce state, press latches and fetch priority logic.
`default_nettype none

module mbdpl_button_bank #(
    parameter int BUTTON_COUNT = 5
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   fire,
    input  wire mbdpl_pkg::item_t                       item,
    input  wire logic [mbdpl_pkg::INTERVAL_WIDTH-1:0]   interval,
    output logic      [mbdpl_pkg::ACTION_WIDTH-1:0]     action_code,
    output logic                                        down_held
);

    logic [BUTTON_COUNT-1:0]               prev_reg;
    logic [BUTTON_COUNT-1:0]               prev_next;
    logic [BUTTON_COUNT-1:0]               stable_reg;
    logic [BUTTON_COUNT-1:0]               stable_next;
    logic [BUTTON_COUNT-1:0]               press_reg;
    logic [BUTTON_COUNT-1:0]               press_next;
    logic [mbdpl_pkg::TIME_WIDTH-1:0]      change_time_reg [BUTTON_COUNT];
    logic [mbdpl_pkg::TIME_WIDTH-1:0]      change_time_next [BUTTON_COUNT];
    logic [BUTTON_COUNT-1:0]               raw_ext;
    logic [BUTTON_COUNT-1:0]               first_press;

    // Buttons above the raw field read low.
    assign raw_ext = BUTTON_COUNT'(item.raw_levels);

    always_comb
    begin
        logic [mbdpl_pkg::TIME_WIDTH-1:0] elapsed;
        logic                             settled;

        elapsed     = '0;
        settled     = 1'b0;
        prev_next   = prev_reg;
        stable_next = stable_reg;
        press_next  = press_reg;
        action_code = '0;
        first_press = '0;
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            change_time_next[i] = change_time_reg[i];
        end

        if (item.kind == mbdpl_pkg::KIND_SAMPLE)
        begin
            prev_next = raw_ext;
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                if (raw_ext[i] != prev_reg[i])
                begin
                    change_time_next[i] = item.now_ms;
                end
                elapsed = item.now_ms - change_time_next[i];
                settled = elapsed >= mbdpl_pkg::TIME_WIDTH'(interval);
                if (settled && (raw_ext[i] != stable_reg[i]))
                begin
                    stable_next[i] = raw_ext[i];
                    if (!raw_ext[i])
                    begin
                        press_next[i] = 1'b1;
                    end
                end
            end
        end
        else
        begin
            // Lowest-numbered latch wins; scan from the top so it lands last.
            for (int i = BUTTON_COUNT - 1; i >= 0; i--)
            begin
                if (press_reg[i])
                begin
                    first_press = '0;
                    first_press[i] = 1'b1;
                    action_code = mbdpl_pkg::ACTION_WIDTH'(i + 1);
                end
            end
            press_next = press_reg & ~first_press;
        end
    end

    generate
        if (BUTTON_COUNT > mbdpl_pkg::DOWN_INDEX)
        begin : g_down
            assign down_held = ~stable_next[mbdpl_pkg::DOWN_INDEX];
        end
        else
        begin : g_no_down
            assign down_held = 1'b0;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '1;
            stable_reg <= '1;
            press_reg  <= '0;
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                change_time_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            prev_reg   <= prev_next;
            stable_reg <= stable_next;
            press_reg  <= press_next;
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                change_time_reg[i] <= change_time_next[i];
            end
        end
    end

    // A sample never reports an action.
    a_sample_no_action: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (item.kind == mbdpl_pkg::KIND_SAMPLE) |-> action_code == '0)
        else $error("sample item produced an action code");

    // A fetch with pending presses clears exactly one latch.
    a_fetch_clears_one: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (item.kind == mbdpl_pkg::KIND_FETCH) && (press_reg != '0)
        |=> $countones(press_reg) == $countones($past(press_reg)) - 1)
        else $error("fetch did not clear exactly one press latch");

    // State moves only on a processed item.
    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(stable_reg) && $stable(press_reg) && $stable(prev_reg))
        else $error("button state changed without an item");

endmodule

`default_nettype wire

>>> verif/tb_multi_button_debounce_press_latch.sv
`timescale 1ns / 1ps
// Self-checking testbench for the multi-button debouncer with press latches.
module tb_multi_button_debounce_press_latch;

    localparam int BUTTONS      = mbdpl_pkg::RAW_WIDTH;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 650;
    localparam int PHASES       = 5;

    typedef struct packed
    {
        logic [mbdpl_pkg::ACTION_WIDTH-1:0] action_code;
        logic                               down_held;
    } report_t;

    // Tracks raw, settled and latched button state and queues the report each item yields.
    class debounce_scoreboard;
        logic [mbdpl_pkg::INTERVAL_WIDTH-1:0] interval;
        logic [BUTTONS-1:0]                   last_raw;
        logic [BUTTONS-1:0]                   settled;
        logic [BUTTONS-1:0]                   latched;
        logic [mbdpl_pkg::TIME_WIDTH-1:0]     changed_at [BUTTONS];
        report_t                              awaited [$];
        int                                   errors;
        int                                   presses_seen;

        function new();
            interval = mbdpl_pkg::INTERVAL_RESET;
            last_raw = '1;
            settled  = '1;
            latched  = '0;
            foreach (changed_at[i])
                changed_at[i] = '0;
            errors       = 0;
            presses_seen = 0;
        endfunction

        function void set_interval(logic [mbdpl_pkg::INTERVAL_WIDTH-1:0] value);
            interval = value;
        endfunction

        function void absorb_item(mbdpl_pkg::kind_t item_kind, logic [BUTTONS-1:0] raw,
                                  logic [mbdpl_pkg::TIME_WIDTH-1:0] now);
            report_t                          r;
            logic [mbdpl_pkg::TIME_WIDTH-1:0] elapsed;
            logic                             found;
            r.action_code = '0;
            found         = 1'b0;
            if (item_kind == mbdpl_pkg::KIND_SAMPLE)
            begin
                for (int i = 0; i < BUTTONS; i++)
                begin
                    if (raw[i] != last_raw[i])
                        changed_at[i] = now;
                    last_raw[i] = raw[i];
                    elapsed = now - changed_at[i];
                    if (elapsed >= {16'b0, interval} && raw[i] != settled[i])
                    begin
                        // high-to-low on the settled level is a press
                        if (!raw[i])
                            latched[i] = 1'b1;
                        settled[i] = raw[i];
                    end
                end
            end
            else
            begin
                for (int i = 0; i < BUTTONS; i++)
                begin
                    if (!found && latched[i])
                    begin
                        latched[i]    = 1'b0;
                        r.action_code = mbdpl_pkg::ACTION_WIDTH'(i + 1);
                        found         = 1'b1;
                    end
                end
            end
            r.down_held = ~settled[mbdpl_pkg::DOWN_INDEX];
            awaited.push_back(r);
        endfunction

        function void compare_result(logic [mbdpl_pkg::OUT_TDATA_WIDTH-1:0] word);
            report_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual tdata %h", $time, word);
                return;
            end
            want = awaited.pop_front();
            if (word[mbdpl_pkg::ACTION_WIDTH-1:0] != want.action_code)
            begin
                errors++;
                $display("%0t: action_code mismatch, expected %0d, actual %0d",
                         $time, want.action_code, word[mbdpl_pkg::ACTION_WIDTH-1:0]);
            end
            if (word[mbdpl_pkg::ACTION_WIDTH] != want.down_held)
            begin
                errors++;
                $display("%0t: down_held mismatch, expected %0b, actual %0b",
                         $time, want.down_held, word[mbdpl_pkg::ACTION_WIDTH]);
            end
            if (word[mbdpl_pkg::ACTION_WIDTH-1:0] != '0)
                presses_seen++;
        endfunction
    endclass

    logic                                  clk;
    logic                                  rst_n;
    logic [mbdpl_pkg::IN_TDATA_WIDTH-1:0]  s_tdata;   // [4:0] raw_levels, [36:5] now_ms, [39:37] zero
    logic                                  s_tuser;   // [0] kind
    logic                                  s_tvalid;
    logic                                  s_tready;
    logic [mbdpl_pkg::OUT_TDATA_WIDTH-1:0] m_tdata;   // [2:0] action_code, [3] down_held, [7:4] zero
    logic                                  m_tvalid;
    logic                                  m_tready;
    logic                                  psel;
    logic                                  penable;
    logic                                  pwrite;
    logic [mbdpl_pkg::ADDR_WIDTH-1:0]      paddr;
    logic [mbdpl_pkg::APB_DATA_WIDTH-1:0]  pwdata;
    logic [mbdpl_pkg::APB_DATA_WIDTH-1:0]  prdata;
    logic                                  pready;

    debounce_scoreboard sb = new();

    int                               quiet_cycles = 0;
    int                               sent_items   = 0;
    int                               samples      = 0;
    int                               fetches      = 0;
    int                               settings     = 1;
    logic                             steady_tx    = 1'b0;
    logic                             steady_rx    = 1'b0;
    logic [mbdpl_pkg::TIME_WIDTH-1:0] clock_ms;
    logic [BUTTONS-1:0]               cur_raw;

    multi_button_debounce_press_latch i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        m_tready <= steady_rx || ($urandom_range(0, 99) >= 26);

    // Transfer monitor and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.compare_result(m_tdata);
            if (s_tvalid && s_tready)
                sb.absorb_item(mbdpl_pkg::kind_t'(s_tuser),
                               s_tdata[mbdpl_pkg::RAW_WIDTH-1:0],
                               s_tdata[mbdpl_pkg::RAW_WIDTH +: mbdpl_pkg::TIME_WIDTH]);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (psel && penable))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, sb.awaited.size());
                $display("tb_multi_button_debounce_press_latch NOT OK");
                $finish;
            end
        end
    end

    task automatic send_item(input mbdpl_pkg::kind_t item_kind,
                             input logic [BUTTONS-1:0] raw,
                             input logic [mbdpl_pkg::TIME_WIDTH-1:0] now);
        if (!steady_tx)
        begin
            while ($urandom_range(0, 99) < 26)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= item_kind;
        s_tdata  <= {3'b000, now, raw};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_items++;
        if (item_kind == mbdpl_pkg::KIND_SAMPLE)
            samples++;
        else
            fetches++;
    endtask

    // Stop sending and wait until every queued report has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_interval(input logic [mbdpl_pkg::INTERVAL_WIDTH-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= mbdpl_pkg::ADDR_DEBOUNCE_INTERVAL;
        pwdata  <= {16'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_interval(value);
        settings++;
    endtask

    // One button event: some bouncing, then a held level, then maybe a few fetches.
    task automatic press_episode(input int unsigned iv);
        logic [BUTTONS-1:0] mask;
        logic [BUTTONS-1:0] target;
        int                 bounces;
        int                 holds;
        int                 reads;
        mask = BUTTONS'($urandom_range(1, 31));
        if ($urandom_range(0, 2) != 0)
            mask = BUTTONS'(1 << $urandom_range(0, BUTTONS - 1));
        target  = cur_raw ^ mask;
        bounces = $urandom_range(0, 4);
        repeat (bounces)
        begin
            clock_ms += $urandom_range(0, iv / 4 + 3);
            send_item(mbdpl_pkg::KIND_SAMPLE, target ^ (BUTTONS'($urandom) & mask),
                      clock_ms);
        end
        cur_raw = target;
        holds   = $urandom_range(1, 3);
        repeat (holds)
        begin
            clock_ms += $urandom_range(iv / 2, iv + iv / 4 + 2);
            send_item(mbdpl_pkg::KIND_SAMPLE, cur_raw, clock_ms);
        end
        reads = $urandom_range(0, 2);
        repeat (reads)
            send_item(mbdpl_pkg::KIND_FETCH, BUTTONS'($urandom), $urandom);
    endtask

    initial
    begin
        logic [mbdpl_pkg::INTERVAL_WIDTH-1:0] phase_iv [PHASES];
        int                                   pick;
        int                                   phase_end;
        logic                                 paused;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = mbdpl_pkg::KIND_SAMPLE;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        paused   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty fetch, threshold at exactly the interval, all five presses,
        // release, timestamp wrap, ignored fetch payload, interval 0 and 65535.
        send_item(mbdpl_pkg::KIND_FETCH, 5'h00, 32'hFFFF_FFFF);
        send_item(mbdpl_pkg::KIND_SAMPLE, 5'h1F, 32'd0);
        send_item(mbdpl_pkg::KIND_SAMPLE, 5'h00, 32'd10);
        send_item(mbdpl_pkg::KIND_SAMPLE, 5'h00, 32'd59);
        send_item(mbdpl_pkg::KIND_SAMPLE, 5'h00, 32'd60);
        repeat (6)
            send_item(mbdpl_pkg::KIND_FETCH, 5'h1F, 32'h0);
        send_item(mbdpl_pkg::KIND_SAMPLE, 5'h1F, 32'd61);
        send_item(mbdpl_pkg::KIND_SAMPLE, 5'h1F, 32'd111);
        send_item(mbdpl_pkg::KIND_SAMPLE, 5'h17, 32'hFFFF_FFF0);
        send_item(mbdpl_pkg::KIND_SAMPLE, 5'h17, 32'h0000_0021);
        send_item(mbdpl_pkg::KIND_SAMPLE, 5'h17, 32'h0000_0022);
        send_item(mbdpl_pkg::KIND_FETCH, 5'h15, 32'h5555_5555);
        send_item(mbdpl_pkg::KIND_SAMPLE, 5'h1F, 32'hA5A5_A5A5);
        send_item(mbdpl_pkg::KIND_SAMPLE, 5'h1F, 32'h5A5A_5A5A);
        drain();
        write_interval(16'd0);
        send_item(mbdpl_pkg::KIND_SAMPLE, 5'h1E, 32'd7);
        send_item(mbdpl_pkg::KIND_FETCH, 5'h0A, 32'h0F0F_0F0F);
        drain();
        write_interval(16'hFFFF);
        send_item(mbdpl_pkg::KIND_SAMPLE, 5'h1D, 32'd1000);
        send_item(mbdpl_pkg::KIND_SAMPLE, 5'h1D, 32'd66534);
        send_item(mbdpl_pkg::KIND_SAMPLE, 5'h1D, 32'd66535);
        send_item(mbdpl_pkg::KIND_FETCH, 5'h00, 32'd0);

        cur_raw     = 5'h1D;
        clock_ms    = 32'd66535;
        phase_iv[0] = mbdpl_pkg::INTERVAL_RESET;
        phase_iv[1] = 16'd0;
        phase_iv[2] = 16'd12;
        phase_iv[3] = 16'hFFFF;
        phase_iv[4] = mbdpl_pkg::INTERVAL_WIDTH'($urandom_range(1, 400));

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            write_interval(phase_iv[p]);
            // one phase runs with no gaps on either side
            steady_tx = (p == 2);
            steady_rx <= (p == 2);
            phase_end = sent_items + RANDOM_ITEMS / PHASES;
            while (sent_items < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    press_episode(phase_iv[p]);
                else if (pick < 85)
                    send_item(mbdpl_pkg::KIND_FETCH, BUTTONS'($urandom), $urandom);
                else
                begin
                    clock_ms = $urandom;
                    send_item(mbdpl_pkg::KIND_SAMPLE, BUTTONS'($urandom), clock_ms);
                end
                if (p == 1 && !paused && sent_items >= phase_end - 60)
                begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        repeat (8) @(posedge clk);

        $display("Ran %0d sample and %0d fetch transfers across %0d interval settings,",
                 samples, fetches, settings);
        $display("including 0, 65535 and timestamp wrap; %0d presses came back as codes.",
                 sb.presses_seen);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("tb_multi_button_debounce_press_latch OK");
        else
            $display("tb_multi_button_debounce_press_latch NOT OK");
        $finish;
    end

endmodule
